/* rtl/fgn_pkg.sv */
// fgn_pkg: shared types and constants for the fractal gradient noise block
// depends on nothing
`default_nettype none
package fgn_pkg;
    localparam int FRAC_BITS = 16;
    localparam int MAX_OCT_HW = 8;

    localparam logic [1:0] REG_OCTAVES = 2'd0;
    localparam logic [1:0] REG_PERSIST = 2'd1;
    localparam logic [1:0] REG_BASEAMP = 2'd2;

    // datapath commands from the controller
    typedef struct packed {
        logic start;      // latch coordinates, clear sums
        logic oct_begin;  // set up one octave
        logic step;       // advance the octave pipeline one phase
        logic div_start;  // start normalizing division
        logic div_step;   // one quotient bit
    } fgn_cmd_t;

    typedef struct packed {
        logic div_done;
    } fgn_stat_t;
endpackage
`default_nettype wire

/* rtl/fgn_ctrl.sv */
// fgn_ctrl: sequencing state machine for one sample
// depends on fgn_pkg
`default_nettype none
module fgn_ctrl
    import fgn_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       start,
    input  wire logic       hold,
    input  wire logic [3:0] oct_num,
    input  fgn_stat_t       stat,
    output fgn_cmd_t        cmd,
    output logic            busy,
    output logic            done
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_OCT  = 3'd1;
    localparam logic [2:0] S_PH   = 3'd2;
    localparam logic [2:0] S_DIVS = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;

    localparam int PHASES = 13;

    logic [2:0] state_reg, state_next;
    logic [3:0] oct_reg, oct_next;
    logic [3:0] ph_reg, ph_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            oct_reg <= '0;
            ph_reg <= '0;
        end else begin
            state_reg <= state_next;
            oct_reg <= oct_next;
            ph_reg <= ph_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        oct_next = oct_reg;
        ph_next = ph_reg;
        cmd = '0;
        done = 1'b0;
        busy = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    cmd.start = 1'b1;
                    oct_next = '0;
                    state_next = (oct_num == 4'd0) ? S_DIVS : S_OCT;
                end
            end
            S_OCT: begin
                cmd.oct_begin = 1'b1;
                ph_next = '0;
                state_next = S_PH;
            end
            S_PH: begin
                cmd.step = 1'b1;
                ph_next = ph_reg + 4'd1;
                if (ph_reg == 4'(PHASES - 1)) begin
                    oct_next = oct_reg + 4'd1;
                    state_next = (oct_reg + 4'd1 == oct_num) ? S_DIVS : S_OCT;
                end
            end
            S_DIVS: begin
                cmd.div_start = 1'b1;
                state_next = S_DIV;
            end
            S_DIV: begin
                if (stat.div_done) begin
                    // wait here while the output register is still occupied
                    if (!hold) begin
                        done = 1'b1;
                        state_next = S_IDLE;
                    end
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

/* rtl/fgn_datapath.sv */
// fgn_datapath: permutation memory, octave evaluation, weighted sums, divider
// depends on fgn_pkg
`default_nettype none
module fgn_datapath
    import fgn_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  fgn_cmd_t         cmd,
    output fgn_stat_t        stat,
    input  wire logic        tbl_we,
    input  wire logic [7:0]  tbl_addr,
    input  wire logic [7:0]  tbl_data,
    input  wire logic [23:0] x_in,
    input  wire logic [23:0] y_in,
    input  wire logic [15:0] persist,
    input  wire logic [15:0] base_amp,
    output logic [15:0]      result
);
    logic [7:0] perm_mem [256];

    logic [39:0] x_reg, y_reg;
    logic [3:0]  ph_reg;
    logic [15:0] amp_reg;
    logic signed [47:0] total_reg;
    logic [19:0] wsum_reg;

    logic [7:0]  x0_reg, y0_reg;
    logic [16:0] fx_reg, fy_reg;
    logic [16:0] t_reg;
    logic [16:0] t2_reg, t3_reg, t4_reg, t5_reg;
    logic [16:0] u_reg, v_reg;
    logic [7:0]  rd_addr;
    logic [7:0]  rd_data_reg;
    logic [7:0]  pa_reg, pb_reg;
    logic [2:0]  h_reg [4];
    logic signed [19:0] g_reg [4];
    logic signed [19:0] lo_reg, hi_reg;
    logic signed [19:0] half_reg;

    // memory
    always_ff @(posedge aclk) begin
        if (tbl_we) perm_mem[tbl_addr] <= tbl_data;
        rd_data_reg <= perm_mem[rd_addr];
    end

    // fade from truncated powers
    function automatic logic [16:0] fade_f(logic [16:0] t3, logic [16:0] t4,
                                           logic [16:0] t5);
        logic signed [22:0] f;
        f = 23'sd6 * $signed({6'd0, t5}) - 23'sd15 * $signed({6'd0, t4})
            + 23'sd10 * $signed({6'd0, t3});
        if (f < 0) return '0;
        if (f > 23'sd65536) return 17'd65536;
        return f[16:0];
    endfunction

    function automatic logic signed [19:0] grad_f(logic [2:0] h,
            logic signed [19:0] dx, logic signed [19:0] dy);
        case (h)
            3'd0: return dx;
            3'd1: return dx + dy;
            3'd2: return dy;
            3'd3: return dy - dx;
            3'd4: return -dx;
            3'd5: return -dx - dy;
            3'd6: return -dy;
            default: return dx - dy;
        endcase
    endfunction

    function automatic logic signed [19:0] lerp_f(logic signed [19:0] a,
            logic signed [19:0] b, logic [16:0] w);
        logic signed [38:0] p;
        p = (b - a) * $signed({1'b0, w});
        return a + 20'(p >>> FRAC_BITS);
    endfunction

    logic [33:0] sq;
    assign sq = {17'd0, t_reg} * {17'd0, (ph_reg < 4'd4) ? fx_reg : fy_reg};

    logic signed [19:0] fxs, fys, one_s;
    assign fxs = $signed({3'd0, fx_reg});
    assign fys = $signed({3'd0, fy_reg});
    assign one_s = 20'sd65536;

    // read addresses by phase
    always_comb begin
        case (ph_reg)
            4'd0: rd_addr = x0_reg;
            4'd1: rd_addr = x0_reg + 8'd1;
            4'd2: rd_addr = pa_reg + y0_reg;
            4'd3: rd_addr = pa_reg + y0_reg + 8'd1;
            4'd4: rd_addr = pb_reg + y0_reg;
            4'd5: rd_addr = pb_reg + y0_reg + 8'd1;
            default: rd_addr = x0_reg;
        endcase
    end

    logic signed [19:0] nval;
    logic signed [19:0] half;
    assign nval = lerp_f(lo_reg, hi_reg, v_reg) + one_s;
    assign half = nval >>> 1;

    logic [35:0] amp_prod;
    assign amp_prod = {20'd0, amp_reg} * {20'd0, persist};

    // division state
    logic [47:0] dividend_reg;
    logic [19:0] rem_reg;
    logic [47:0] quo_reg;
    logic [5:0]  dcnt_reg;
    logic        dzero_reg;
    logic [20:0] rtry;
    assign rtry = {rem_reg, dividend_reg[47]} - {1'b0, wsum_reg};

    logic signed [38:0] wprod;
    assign wprod = $signed({1'b0, amp_reg}) * $signed({{3{half_reg[19]}}, half_reg});

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            x_reg <= {15'd0, x_in, 1'b0};
            y_reg <= {15'd0, y_in, 1'b0};
            amp_reg <= base_amp;
            total_reg <= '0;
            wsum_reg <= '0;
        end
        if (cmd.oct_begin) begin
            x0_reg <= x_reg[23:16];
            y0_reg <= y_reg[23:16];
            fx_reg <= {1'b0, x_reg[15:0]};
            fy_reg <= {1'b0, y_reg[15:0]};
            t_reg <= {1'b0, x_reg[15:0]};
            ph_reg <= '0;
        end
        if (cmd.step) begin
            ph_reg <= ph_reg + 4'd1;
            // fade powers, x in phases 0-3, y in 4-7
            case (ph_reg)
                4'd0, 4'd4: begin t2_reg <= sq[32:16]; t_reg <= sq[32:16]; end
                4'd1, 4'd5: begin t3_reg <= sq[32:16]; t_reg <= sq[32:16]; end
                4'd2, 4'd6: begin t4_reg <= sq[32:16]; t_reg <= sq[32:16]; end
                default: ;
            endcase
            if (ph_reg == 4'd3) t_reg <= fy_reg;
            // fade polynomial one phase after the last power
            if (ph_reg == 4'd4) u_reg <= fade_f(t3_reg, t4_reg, t5_reg);
            if (ph_reg == 4'd8) v_reg <= fade_f(t3_reg, t4_reg, t5_reg);
            t5_reg <= sq[32:16];
            // hash reads, data registered and used in the following phase
            if (ph_reg == 4'd1) pa_reg <= rd_data_reg;
            if (ph_reg == 4'd2) pb_reg <= rd_data_reg;
            if (ph_reg == 4'd3) h_reg[0] <= rd_data_reg[2:0];
            if (ph_reg == 4'd4) h_reg[2] <= rd_data_reg[2:0];
            if (ph_reg == 4'd5) h_reg[1] <= rd_data_reg[2:0];
            if (ph_reg == 4'd6) h_reg[3] <= rd_data_reg[2:0];
            if (ph_reg == 4'd8) begin
                g_reg[0] <= grad_f(h_reg[0], fxs, fys);
                g_reg[1] <= grad_f(h_reg[1], fxs - one_s, fys);
                g_reg[2] <= grad_f(h_reg[2], fxs, fys - one_s);
                g_reg[3] <= grad_f(h_reg[3], fxs - one_s, fys - one_s);
            end
            if (ph_reg == 4'd9) lo_reg <= lerp_f(g_reg[0], g_reg[1], u_reg);
            if (ph_reg == 4'd10) hi_reg <= lerp_f(g_reg[2], g_reg[3], u_reg);
            if (ph_reg == 4'd11) half_reg <= half;
            if (ph_reg == 4'd12) begin
                total_reg <= total_reg + 48'(wprod);
                wsum_reg <= wsum_reg + {4'd0, amp_reg};
                amp_reg <= amp_prod[31:16];
                x_reg <= x_reg << 1;
                y_reg <= y_reg << 1;
            end
        end
        if (cmd.div_start) begin
            dzero_reg <= (wsum_reg == '0) || (total_reg <= 0);
            dividend_reg <= total_reg;
            rem_reg <= '0;
            quo_reg <= '0;
            dcnt_reg <= '0;
        end
        if (cmd.div_step) begin
            dcnt_reg <= dcnt_reg + 6'd1;
            dividend_reg <= dividend_reg << 1;
            if (!rtry[20]) begin
                rem_reg <= rtry[19:0];
                quo_reg <= {quo_reg[46:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[18:0], dividend_reg[47]};
                quo_reg <= {quo_reg[46:0], 1'b0};
            end
        end
    end

    assign stat.div_done = (dcnt_reg == 6'd48);
    assign result = dzero_reg ? 16'd0 :
                    (quo_reg[47:16] != '0) ? 16'hFFFF : quo_reg[15:0];

    logic unused;
    assign unused = aresetn ^ ^t2_reg ^ ^x_reg[39:24] ^ ^y_reg[39:24]
                  ^ ^amp_prod[35:32] ^ ^amp_prod[15:0] ^ ^sq[33] ^ ^sq[15:0]
                  ^ ^nval[0];
endmodule
`default_nettype wire

/* rtl/fractal_gradient_noise_2d.sv */
// fractal_gradient_noise_2d: top level, handshakes, config registers
// a sample runs from acceptance to its word through a setup state and a 13-phase sequence
// per octave (up to 8 octaves), then the bit-serial 48-step divider; a load writes the table
// at acceptance and does not make the block busy
// one sample at a time, next word taken the cycle after the result is stored;
// the next word is taken while a result waits in m_ registers
// reset: synchronous active-low aresetn clears control and loads register defaults;
// the permutation table is not cleared and must be loaded before use
`default_nettype none
module fractal_gradient_noise_2d
    import fgn_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_op,
    input  wire logic [7:0]  s_table_index,
    input  wire logic [7:0]  s_table_value,
    input  wire logic [23:0] s_x_coord,
    input  wire logic [23:0] s_y_coord,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_noise_value
);
    logic [3:0]  oct_reg;
    logic [15:0] persist_reg, base_reg;
    logic        m_valid_reg;
    logic [15:0] m_data_reg;

    fgn_cmd_t  cmd;
    fgn_stat_t stat;
    logic busy, done, accept, start, hold;
    logic [3:0] oct_num;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oct_reg <= 4'd4;
            persist_reg <= 16'd32768;
            base_reg <= 16'd65535;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_OCTAVES: oct_reg <= cfg_data[3:0];
                REG_PERSIST: persist_reg <= cfg_data;
                REG_BASEAMP: base_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign oct_num = (oct_reg > 4'(MAX_OCT_HW)) ? 4'(MAX_OCT_HW) : oct_reg;

    // input side free whenever no sample runs
    assign s_ready = !busy;
    assign accept = s_valid && s_ready;
    assign start = accept && s_op;

    // a finished sample waits while the held word is not taken
    assign hold = m_valid_reg && !m_ready;

    fgn_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .start(start), .hold(hold), .oct_num(oct_num),
        .stat(stat), .cmd(cmd), .busy(busy), .done(done)
    );

    logic [15:0] result;
    fgn_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .tbl_we(accept && !s_op), .tbl_addr(s_table_index),
        .tbl_data(s_table_value), .x_in(s_x_coord), .y_in(s_y_coord),
        .persist(persist_reg), .base_amp(base_reg), .result(result)
    );

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (done) m_data_reg <= result;
    end

    assign m_valid = m_valid_reg;
    assign m_noise_value = m_data_reg;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> !s_ready) else $error("input taken while busy");
    a_done_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> m_valid) else $error("result lost");
    a_no_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> (!m_valid_reg || m_ready)) else $error("result overwritten");
`endif
endmodule
`default_nettype wire

/* tb/sv/tb_fractal_gradient_noise_2d.sv */
// testbench for fractal_gradient_noise_2d: random loads and samples checked
// against an in-bench fixed point noise predictor; depends on fgn_pkg and the rtl
`timescale 1ns / 1ps
module tb_fractal_gradient_noise_2d
    import fgn_pkg::*;
();

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;
    localparam longint ONE_Q = 64'sd65536;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic        op;
        logic [7:0]  idx;
        logic [7:0]  val;
        logic [23:0] x;
        logic [23:0] y;
    } word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = REG_OCTAVES;
    logic [15:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_op = 1'b0;
    logic [7:0]  s_table_index = '0;
    logic [7:0]  s_table_value = '0;
    logic [23:0] s_x_coord = '0;
    logic [23:0] s_y_coord = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_noise_value;

    fractal_gradient_noise_2d dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state, mirrors the block's table and registers
    logic [7:0]  perm [256];
    logic [3:0]  octaves_q = 4'd4;
    logic [15:0] persist_q = 16'd32768;
    logic [15:0] base_amp_q = 16'hFFFF;

    word_t       pending_words[$];
    logic [15:0] expected_noise[$];
    int          errors = 0;
    int          checked = 0;
    int          samples_sent = 0;
    longint      cycles = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          hold_off = 0;

    // floor(v / 2^16) for signed values
    function automatic longint floor_q(longint v);
        return v >>> 16;
    endfunction

    function automatic longint fade_q(longint t);
        longint t2, t3, t4, t5, f;
        t2 = (t * t) >> 16;
        t3 = (t2 * t) >> 16;
        t4 = (t3 * t) >> 16;
        t5 = (t4 * t) >> 16;
        f = 6 * t5 - 15 * t4 + 10 * t3;
        if (f < 0) f = 0;
        if (f > ONE_Q) f = ONE_Q;
        return f;
    endfunction

    function automatic longint grad_dot(logic [7:0] h, longint dx, longint dy);
        case (h[2:0])
            3'd0: return dx;
            3'd1: return dx + dy;
            3'd2: return dy;
            3'd3: return dy - dx;
            3'd4: return -dx;
            3'd5: return -dx - dy;
            3'd6: return -dy;
            default: return dx - dy;
        endcase
    endfunction

    function automatic longint blend(longint a, longint b, longint w);
        return a + floor_q((b - a) * w);
    endfunction

    function automatic logic [7:0] corner_hash(logic [7:0] cx, logic [7:0] cy);
        logic [7:0] p;
        p = perm[cx];
        return perm[8'(p + cy)];
    endfunction

    // one octave, returns (noise + 1) / 2 in signed q16
    function automatic longint octave_noise(logic [63:0] sx, logic [63:0] sy);
        logic [7:0] x0, y0, x1, y1;
        longint fx, fy, u, v, lo, hi, n;
        x0 = sx[23:16];
        y0 = sy[23:16];
        x1 = x0 + 8'd1;
        y1 = y0 + 8'd1;
        fx = longint'(sx[15:0]);
        fy = longint'(sy[15:0]);
        u = fade_q(fx);
        v = fade_q(fy);
        lo = blend(grad_dot(corner_hash(x0, y0), fx, fy),
                   grad_dot(corner_hash(x1, y0), fx - ONE_Q, fy), u);
        hi = blend(grad_dot(corner_hash(x0, y1), fx, fy - ONE_Q),
                   grad_dot(corner_hash(x1, y1), fx - ONE_Q, fy - ONE_Q), u);
        n = blend(lo, hi, v) + ONE_Q;
        return n >>> 1;
    endfunction

    function automatic logic [15:0] fractal_noise(logic [23:0] x, logic [23:0] y);
        int n;
        longint amp, total, wsum, q;
        amp = base_amp_q;
        total = 0;
        wsum = 0;
        n = (octaves_q > 8) ? 8 : octaves_q;
        for (int i = 0; i < n; i++) begin
            total += octave_noise(64'(x) << (i + 1), 64'(y) << (i + 1)) * amp;
            wsum += amp;
            amp = (amp * persist_q) >> 16;
        end
        q = 0;
        if (wsum > 0 && total > 0) q = total / wsum;
        if (q > 65535) q = 65535;
        return q[15:0];
    endfunction

    // driver: bursts and gaps, payload held until accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_words.size() > 0 && gap_left == 0) begin
                word_t w;
                w = pending_words.pop_front();
                s_valid <= 1'b1;
                s_op <= w.op;
                s_table_index <= w.idx;
                s_table_value <= w.val;
                s_x_coord <= w.x;
                s_y_coord <= w.y;
                if (w.op == OP_LOAD) begin
                    perm[w.idx] = w.val;
                end else begin
                    expected_noise.push_back(fractal_noise(w.x, w.y));
                    samples_sent++;
                end
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 20);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                end else begin
                    burst_left--;
                end
            end else begin
                s_valid <= 1'b0;
                if (gap_left > 0) gap_left--;
            end
        end
    end

    // receiver stall pattern, with one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= (cycles % 512 < 256) ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    // monitor: compare each word against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_noise.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected word noise=%0d", m_noise_value);
            end else begin
                logic [15:0] exp_v;
                exp_v = expected_noise.pop_front();
                checked++;
                if (exp_v !== m_noise_value) begin
                    errors++;
                    if (errors <= 10)
                        $display("noise mismatch: expected %0d got %0d", exp_v, m_noise_value);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic push_word(logic op, logic [7:0] idx, logic [7:0] val,
                             logic [23:0] x, logic [23:0] y);
        pending_words.push_back({op, idx, val, x, y});
    endtask

    task automatic push_sample(logic [23:0] x, logic [23:0] y);
        push_word(OP_SAMPLE, 8'($urandom), 8'($urandom), x, y);
    endtask

    // wait until every word is back, then the block's worst latency
    task automatic drain();
        while (pending_words.size() > 0 || s_valid || expected_noise.size() > 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_OCTAVES: octaves_q = data[3:0];
            REG_PERSIST: persist_q = data;
            default:     base_amp_q = data;
        endcase
    endtask

    task automatic random_samples(int count);
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 9))
                0: push_word(OP_LOAD, 8'($urandom), 8'($urandom), 24'($urandom),
                             24'($urandom));
                1: push_sample(24'hFFFFFF - 24'($urandom_range(0, 3)), 24'($urandom));
                2: push_sample({8'($urandom), 16'h0}, {8'($urandom), 16'hFFFF});
                default: push_sample(24'($urandom), 24'($urandom));
            endcase
        end
    endtask

    initial begin
        int phase_oct [6];
        int phase_per [6];
        int phase_amp [6];
        phase_oct = '{4, 1, 8, 15, 0, 3};
        phase_per = '{32768, 0, 65535, 12345, 40000, 65535};
        phase_amp = '{65535, 1, 65535, 30000, 500, 1};
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // fill the whole table first, so no unwritten entry is ever read
        for (int i = 0; i < 256; i++)
            push_word(OP_LOAD, 8'(i), 8'($urandom), 24'($urandom), 24'($urandom));
        // directed corners at reset settings
        push_sample(24'h0, 24'h0);
        push_sample(24'hFFFFFF, 24'hFFFFFF);
        push_sample(24'h00FFFF, 24'hFF0000);
        push_sample(24'h008000, 24'h008000);
        push_sample(24'hFF0001, 24'h000001);
        push_word(OP_LOAD, 8'hFF, 8'hFF, 24'hFFFFFF, 24'hFFFFFF);
        push_word(OP_LOAD, 8'h00, 8'h00, 24'h0, 24'h0);
        push_sample(24'h123456, 24'hABCDEF);
        drain();

        // long receiver hold-off while the sender keeps offering
        hold_off = 3000;
        random_samples(60);
        drain();

        for (int p = 0; p < 6; p++) begin
            write_reg(REG_OCTAVES, 16'(phase_oct[p]));
            write_reg(REG_PERSIST, 16'(phase_per[p]));
            write_reg(REG_BASEAMP, 16'(phase_amp[p]));
            push_sample(24'h0, 24'h0);
            push_sample(24'hFFFFFF, 24'hFFFFFF);
            random_samples(200);
            drain();
        end

        $display("covered %0d samples over six register settings incl. 0, 1, 8, 15 octaves",
                 samples_sent);
        $display("%0d noise words checked, %0d mismatches", checked, errors);
        if (errors == 0 && expected_noise.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

/* filelist.f */
rtl/fgn_pkg.sv
rtl/fgn_ctrl.sv
rtl/fgn_datapath.sv
rtl/fractal_gradient_noise_2d.sv
tb/sv/tb_fractal_gradient_noise_2d.sv
